/* hw/rtl/dcds_pkg.sv */
package dcds_pkg;

    // Capacity of the sorting row, in commands per frame.
    localparam int MAX_ENTRIES = 64;
    // The fill count must also be able to hold the full capacity.
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic signed [15:0] depth_key;
        logic        [15:0] payload_tag;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sorted_key;
        logic        [15:0] sorted_tag;
        logic               run_last;
        logic               dropped_any;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] key;
        logic        [15:0] tag;
    } t_entry;

    // Controller to datapath.
    typedef struct packed {
        logic push;  // accept the presented command into the row
        logic pop;   // the head entry has been taken downstream
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic last;  // exactly one entry left in the row
    } t_sts;

endpackage

/* hw/rtl/dcds_datapath.sv */
module dcds_datapath
    import dcds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    output t_sts      o_sts,
    output t_out_item o_item
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovf;
    logic             n_ovf;
    t_entry           r_cell [MAX_ENTRIES];
    t_entry           n_cell [MAX_ENTRIES];
    t_entry           w_prev [MAX_ENTRIES];
    t_entry           w_next [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_gt;
    logic [MAX_ENTRIES-1:0] w_prev_gt;
    t_entry           w_new;
    logic             w_full;
    logic             w_ins;

    assign w_new.key = i_item.depth_key;
    assign w_new.tag = i_item.payload_tag;
    assign w_full    = (r_count == CNT_W'(MAX_ENTRIES));
    assign w_ins     = i_cmd.push && !w_full;

    // Each cell compares its key with the incoming one; occupied cells with a
    // strictly greater key move up one place, the new entry fills the gap.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g]    = w_new;
            assign w_prev_gt[g] = 1'b0;
        end else begin : g_body
            assign w_prev[g]    = r_cell[g-1];
            assign w_prev_gt[g] = w_gt[g-1];
        end
        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign w_next[g] = r_cell[g];
        end else begin : g_inner
            assign w_next[g] = r_cell[g+1];
        end

        assign w_gt[g] = (CNT_W'(g) < r_count) &&
                         ($signed(r_cell[g].key) > $signed(i_item.depth_key));

        always_comb begin
            n_cell[g] = r_cell[g];
            if (i_cmd.pop) begin
                n_cell[g] = w_next[g];
            end else if (w_ins) begin
                if (w_prev_gt[g]) begin
                    n_cell[g] = w_prev[g];
                end else if (w_gt[g] || (r_count == CNT_W'(g))) begin
                    n_cell[g] = w_new;
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
            if (o_sts.last) begin
                n_ovf = 1'b0;
            end
        end else if (i_cmd.push) begin
            if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            r_cell[k] <= n_cell[k];
        end
    end

    assign o_sts.last         = (r_count == CNT_W'(1));
    assign o_item.sorted_key  = r_cell[0].key;
    assign o_item.sorted_tag  = r_cell[0].tag;
    assign o_item.run_last    = o_sts.last;
    assign o_item.dropped_any = r_ovf;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond capacity");

    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_count != '0)
        else $error("pop from empty row");

    a_head_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CNT_W'(2) |-> $signed(r_cell[0].key) <= $signed(r_cell[1].key))
        else $error("row head out of order");

    a_frame_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop && o_sts.last |=> r_count == '0 && !r_ovf)
        else $error("row not cleared after last result");

endmodule

/* hw/rtl/dcds_ctrl.sv */
module dcds_ctrl
    import dcds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_frame_end,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_COLLECT = 2'b01,
        S_EMIT    = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready  = (r_state == S_COLLECT);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_cmd.push  = i_in_valid && o_in_ready;
    assign o_cmd.pop   = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_COLLECT: begin
                if (o_cmd.push && i_frame_end) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_cmd.pop && i_sts.last) begin
                    n_state = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    a_end_starts_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push && i_frame_end |=> r_state == S_EMIT)
        else $error("frame end did not start emission");

    a_last_ends_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop && i_sts.last |=> r_state == S_COLLECT)
        else $error("emission did not stop after last result");

    a_state_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

endmodule

/* hw/rtl/draw_command_depth_sort.sv */
// Latency: a frame-end transaction's first result is valid the cycle after it is accepted.
// Throughput: one input transaction per cycle while collecting (compare-and-shift row).
// Emission: one result per cycle from the head of the row while the receiver is ready,
//   no input taken meanwhile; after a frame end, input ready stays low until every
//   stored command has been emitted, however long the receiver stalls.
// Reset (i_rst_n low, synchronous): clear fill count, overflow flag and controller
//   state; row contents are left as they are and never read before being written.
module draw_command_depth_sort
    import dcds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // Command and status between the controller and the sorting row.
    t_cmd w_cmd;
    t_sts w_sts;

    // Controller: hold the collect/emit phase and turn handshakes into
    // push and pop commands for the row.
    dcds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_frame_end (i_in_item.frame_end),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // Datapath: a register row kept in ascending key order. A push inserts
    // after every entry with an equal or smaller key, so equal keys keep
    // their arrival order; a push into a full row is dropped and flagged.
    // A pop advances the row by one so the head always holds the next result.
    dcds_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_in_item),
        .o_sts   (w_sts),
        .o_item  (o_out_item)
    );

endmodule

/* sim/draw_command_depth_sort_tb.sv */
`timescale 1ns / 100ps

module draw_command_depth_sort_tb;
    import dcds_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    draw_command_depth_sort u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Free-running 10 ns clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Commands waiting to be driven, with a flag per command that makes the
    // driver hold off until every sorted draw of earlier frames has come out.
    t_in_item  pending_cmds[$];
    bit        pending_hold[$];

    // Sorted draws predicted but not yet seen on the output channel.
    t_out_item expected_draws[$];

    // Shadow of the sorting row: ascending keys, ties in arrival order.
    t_entry    sorted_row[MAX_ENTRIES];
    int        row_fill;
    bit        row_dropped;

    int        fault_count;
    bit        cmd_taken;

    // Sender burst shaping and receiver stall pattern.
    int        burst_left;
    int        gap_left;
    int        stall_mode;
    int        stall_cycle;
    int        stall_run;

    t_out_item want_draw;

    // Place one accepted command into the shadow row; on frame end, release
    // the whole row as expected draws and clear it.
    function automatic void insert_command(input t_in_item cmd);
        int        pos;
        t_out_item draw;
        if (row_fill < MAX_ENTRIES) begin
            pos = row_fill;
            // Strict compare: equal keys stay behind the ones already stored.
            while (pos > 0 && $signed(sorted_row[pos-1].key) > $signed(cmd.depth_key)) begin
                sorted_row[pos] = sorted_row[pos-1];
                pos--;
            end
            sorted_row[pos].key = cmd.depth_key;
            sorted_row[pos].tag = cmd.payload_tag;
            row_fill++;
        end else begin
            // Row full: drop the command, frame end included, and flag it.
            row_dropped = 1'b1;
        end
        if (cmd.frame_end) begin
            for (int k = 0; k < row_fill; k++) begin
                draw.sorted_key  = sorted_row[k].key;
                draw.sorted_tag  = sorted_row[k].tag;
                draw.run_last    = (k == row_fill - 1);
                draw.dropped_any = row_dropped;
                expected_draws.push_back(draw);
            end
            row_fill    = 0;
            row_dropped = 1'b0;
        end
    endfunction

    task automatic queue_command(input logic signed [15:0] key, input logic [15:0] tag,
                                 input bit last, input bit hold);
        t_in_item cmd;
        cmd.depth_key   = key;
        cmd.payload_tag = tag;
        cmd.frame_end   = last;
        pending_cmds.push_back(cmd);
        pending_hold.push_back(hold);
    endtask

    // Queue one frame of random commands. A span of zero draws keys from the
    // full range; otherwise keys are packed into a narrow window around zero
    // so that ties are common and stability is exercised.
    task automatic queue_frame(input int size, input int span, input bit hold);
        int key;
        for (int i = 0; i < size; i++) begin
            if (span == 0)
                key = $urandom;
            else
                key = int'($urandom_range(2 * span, 0)) - span;
            queue_command(key[15:0], 16'($urandom), (i == size - 1), hold && (i == 0));
        end
    endtask

    // Driver: present commands at the falling edge, in bursts of random
    // length with random gaps. Hold the transaction until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            cmd_taken = 1'b0;
        end else if (i_in_valid && !cmd_taken) begin
            // Hold: valid and payload stay as they are until accepted.
        end else begin
            cmd_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() == 0 ||
                         (pending_hold[0] && expected_draws.size() != 0)) begin
                // Nothing left, or drain the output before this frame starts.
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_item  <= pending_cmds.pop_front();
                void'(pending_hold.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    // A gap of zero gives stretches with no idling at all.
                    gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                    burst_left = $urandom_range(30, 1);
                end
            end
        end
    end

    // Receiver: ready pattern follows a mode picked anew at random whenever the stall
    // counter wraps - always ready, coin toss, mostly stalled, or long stall runs.
    always @(negedge i_clk) begin
        stall_cycle++;
        if (stall_cycle >= 50) begin
            stall_cycle = 0;
            stall_mode  = $urandom_range(3, 0);
        end
        case (stall_mode)
            0: begin
                i_out_ready <= 1'b1;
            end
            1: begin
                i_out_ready <= 1'($urandom_range(1, 0));
            end
            2: begin
                i_out_ready <= ($urandom_range(3, 0) == 0);
            end
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                    if ($urandom_range(7, 0) == 0)
                        stall_run = $urandom_range(20, 5);
                end
            end
        endcase
    end

    // Monitor: sample both channels at the rising edge. An accepted command
    // advances the prediction; an accepted draw is checked against the oldest
    // expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                insert_command(i_in_item);
                cmd_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_draws.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected draw: key %0d tag %h last %b dropped %b",
                                 o_out_item.sorted_key, o_out_item.sorted_tag,
                                 o_out_item.run_last, o_out_item.dropped_any);
                end else begin
                    want_draw = expected_draws.pop_front();
                    if (o_out_item.sorted_key  !== want_draw.sorted_key  ||
                        o_out_item.sorted_tag  !== want_draw.sorted_tag  ||
                        o_out_item.run_last    !== want_draw.run_last    ||
                        o_out_item.dropped_any !== want_draw.dropped_any) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("draw mismatch: expected key %0d tag %h last %b dropped %b",
                                     want_draw.sorted_key, want_draw.sorted_tag,
                                     want_draw.run_last, want_draw.dropped_any);
                            $display("               got key %0d tag %h last %b dropped %b",
                                     o_out_item.sorted_key, o_out_item.sorted_tag,
                                     o_out_item.run_last, o_out_item.dropped_any);
                        end
                    end
                end
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #3000000;
        $display("draw_command_depth_sort test failed");
        $finish;
    end

    initial begin
        int frame_no;
        int total;
        int pick;
        int size;
        int waited;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        row_fill    = 0;
        row_dropped = 1'b0;
        fault_count = 0;
        cmd_taken   = 1'b0;
        burst_left  = $urandom_range(30, 1);
        gap_left    = 0;
        stall_mode  = 0;
        stall_cycle = 0;
        stall_run   = 0;

        // Directed: one-command frames at both key extremes.
        queue_command(16'sh8000, 16'h0000, 1'b1, 1'b0);
        queue_command(16'sh7FFF, 16'hFFFF, 1'b1, 1'b0);
        // Mixed extremes with repeated keys; ties must keep arrival order.
        queue_command(16'sh7FFF, 16'h0001, 1'b0, 1'b1);
        queue_command(16'sh8000, 16'h0002, 1'b0, 1'b0);
        queue_command(16'sh0000, 16'h0003, 1'b0, 1'b0);
        queue_command(16'shFFFF, 16'h0004, 1'b0, 1'b0);
        queue_command(16'sh0001, 16'h0005, 1'b0, 1'b0);
        queue_command(16'sh0000, 16'h0006, 1'b0, 1'b0);
        queue_command(16'sh8000, 16'h0007, 1'b0, 1'b0);
        queue_command(16'sh7FFF, 16'h0008, 1'b0, 1'b0);
        queue_command(16'sh0000, 16'hFFFF, 1'b1, 1'b0);
        // Strictly descending keys: every insert shifts the whole row.
        for (int i = 4; i >= 0; i--)
            queue_command(i[15:0], 16'h5555 ^ i[15:0], (i == 0), 1'b0);
        // All keys equal: output order must be arrival order.
        queue_command(16'sh0005, 16'h8000, 1'b0, 1'b1);
        queue_command(16'sh0005, 16'h7FFF, 1'b0, 1'b0);
        queue_command(16'sh0005, 16'hAAAA, 1'b1, 1'b0);

        // Random frames. Force an exactly full frame, a frame whose frame end
        // is itself dropped, and a heavily overflowing one; otherwise mostly
        // short frames with the odd long or overflowing one.
        total    = pending_cmds.size();
        frame_no = 0;
        while (total < 460) begin
            if (frame_no == 2) begin
                size = MAX_ENTRIES;
            end else if (frame_no == 5) begin
                size = MAX_ENTRIES + 1;
            end else if (frame_no == 9) begin
                size = MAX_ENTRIES + 16;
            end else begin
                pick = $urandom_range(9, 0);
                if (pick <= 6)
                    size = $urandom_range(12, 1);
                else if (pick == 7)
                    size = $urandom_range(MAX_ENTRIES - 1, 13);
                else if (pick == 8)
                    size = $urandom_range(MAX_ENTRIES + 2, MAX_ENTRIES);
                else
                    size = $urandom_range(MAX_ENTRIES + 26, MAX_ENTRIES + 3);
            end
            // Trim the closing frames so the run stays near its item budget.
            if (frame_no > 9 && size > 460 - total)
                size = 460 - total;
            queue_frame(size, $urandom_range(1, 0) ? 0 : 3, (frame_no % 4 == 3));
            total += size;
            frame_no++;
        end

        // Hold reset, then release it at a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every command has been taken.
        while (pending_cmds.size() != 0 || i_in_valid)
            @(posedge i_clk);

        // Drain the remaining draws, bounded.
        waited = 0;
        while (expected_draws.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_draws.size() != 0) begin
            fault_count++;
            $display("%0d expected draws never arrived", expected_draws.size());
        end

        // Let the block settle; any stray draw here is caught by the monitor.
        repeat (MAX_ENTRIES + 8) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("draw_command_depth_sort test passed");
        end else begin
            $display("draw_command_depth_sort test failed");
        end
        $finish;
    end

endmodule
